/* design/srpn_pkg.sv */
// shared types and constants of the rpn stack calculator
`default_nettype none
package srpn_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned DEPTH_W   = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_PEEK = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6,
    OP_MOD  = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_SECOND,
    S_MUL,
    S_DIV,
    S_FIX,
    S_WRITE
  } state_e;

  // magnitude of a two's complement word, most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

endpackage
`default_nettype wire

/* design/stack_rpn_calculator_unit.sv */
// top level of the rpn stack calculator: stack memory, sequencer and divider
// accept to result strobe: push and plain errors answer from idle; pop/peek read the top
// entry, divide by zero also the second, add/sub then write, multiply via S_MUL, and
// divide/modulo, the slowest, via S_DIV and S_FIX before the write; the receiver cannot stall
// one item at a time: busy is high until the strobe, and the next item may be accepted
// in its strobe cycle; rst_ni clears the sequencer and the entry count, not the stack memory
`default_nettype none
module stack_rpn_calculator_unit #(
  parameter int unsigned DEPTH = srpn_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [srpn_pkg::OP_W-1:0]     op_i,
  input  wire logic signed [srpn_pkg::DATA_W-1:0] operand_i,
  output logic                               done_o,
  output logic [srpn_pkg::STATUS_W-1:0]      status_o,
  output logic signed [srpn_pkg::DATA_W-1:0] value_o,
  output logic [srpn_pkg::DEPTH_W-1:0]       depth_o
);
  import srpn_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DATA_W);

  // sequencer state
  state_e state_q, state_d;
  op_e    op_q, op_d;

  // entry count and the addresses derived from it
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_m1, cnt_m2, cnt_p1;
  logic          full, empty, below_two;

  // stack memory with one write and one registered read port
  logic [DATA_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rdata_q;

  // operands and arithmetic result
  logic [DATA_W-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic [DATA_W-1:0] prod_lo;

  // restoring divider over magnitudes
  logic [DATA_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [IW-1:0]     it_q, it_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   div_sh, div_diff;
  logic [DATA_W-1:0] div_sel;

  // result registers
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [31:0]       depth_ext;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  logic accept;
  logic is_binary;

  assign accept    = start && !busy;
  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_m2    = cnt_q - CW'(2);
  assign cnt_p1    = cnt_q + CW'(1);
  assign full      = (cnt_q == CW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign below_two = (cnt_q < CW'(2));
  assign is_binary = !(op_e'(op_i) == OP_PUSH || op_e'(op_i) == OP_POP ||
                       op_e'(op_i) == OP_PEEK);

  // top entry is read from idle, the one below it while the top arrives
  assign rd_addr = (state_q == S_TOP) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

  // low word of the product; operands are registered
  assign prod_lo = a_q * b_q;

  // one quotient bit per cycle
  assign div_sh   = {rem_q, quo_q[DATA_W-1]};
  assign div_diff = div_sh - {1'b0, dvs_q};
  assign div_sel  = (op_q == OP_DIV) ? quo_q : rem_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(op_i) == OP_PUSH) begin
            state_d = S_IDLE;
          end else if (is_binary) begin
            state_d = below_two ? S_IDLE : S_TOP;
          end else begin
            state_d = empty ? S_IDLE : S_TOP;
          end
        end
      end
      S_TOP: begin
        state_d = (op_q == OP_POP || op_q == OP_PEEK) ? S_IDLE : S_SECOND;
      end
      S_SECOND: begin
        case (op_q)
          OP_ADD, OP_SUB: state_d = S_WRITE;
          OP_MUL:         state_d = S_MUL;
          OP_DIV, OP_MOD: state_d = (b_q == '0) ? S_IDLE : S_DIV;
          default:        state_d = S_IDLE;
        endcase
      end
      S_MUL:   state_d = S_WRITE;
      S_DIV:   state_d = (it_q == IW'(DATA_W - 1)) ? S_FIX : S_DIV;
      S_FIX:   state_d = S_WRITE;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    op_d     = op_q;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    res_d    = res_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    it_d     = it_q;
    neg_d    = neg_q;
    mem_we   = 1'b0;
    wr_addr  = cnt_q[AW-1:0];
    wr_data  = operand_i;
    done_d   = 1'b0;
    status_d = status_q;
    value_d  = value_q;
    depth_ext = 32'(cnt_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(op_i);
          if (op_e'(op_i) == OP_PUSH) begin
            done_d  = 1'b1;
            value_d = '0;
            if (full) begin
              status_d = ST_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              cnt_d     = cnt_p1;
              status_d  = ST_OK;
              depth_ext = 32'(cnt_p1);
            end
          end else if (is_binary && below_two) begin
            done_d   = 1'b1;
            status_d = ST_UNDERFLOW;
            value_d  = '0;
          end else if (!is_binary && empty) begin
            done_d   = 1'b1;
            status_d = ST_EMPTY;
            value_d  = '0;
          end
        end
      end
      S_TOP: begin
        b_d = rdata_q;
        if (op_q == OP_POP || op_q == OP_PEEK) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          value_d  = rdata_q;
          if (op_q == OP_POP) begin
            cnt_d     = cnt_m1;
            depth_ext = 32'(cnt_m1);
          end
        end
      end
      S_SECOND: begin
        a_d = rdata_q;
        case (op_q)
          OP_ADD: res_d = rdata_q + b_q;
          OP_SUB: res_d = rdata_q - b_q;
          OP_DIV, OP_MOD: begin
            if (b_q == '0) begin
              done_d   = 1'b1;
              status_d = ST_DIVZERO;
              value_d  = '0;
            end else begin
              rem_d = '0;
              quo_d = magnitude(rdata_q);
              dvs_d = magnitude(b_q);
              it_d  = '0;
              neg_d = (op_q == OP_DIV) ? (rdata_q[DATA_W-1] ^ b_q[DATA_W-1])
                                       : rdata_q[DATA_W-1];
            end
          end
          default: ;
        endcase
      end
      S_MUL: res_d = prod_lo;
      S_DIV: begin
        if (!div_diff[DATA_W]) begin
          rem_d = div_diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = div_sh[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        it_d = it_q + IW'(1);
      end
      S_FIX: res_d = neg_q ? (DATA_W'(0) - div_sel) : div_sel;
      S_WRITE: begin
        // result replaces the lower operand, the top entry is dropped
        mem_we    = 1'b1;
        wr_addr   = cnt_m2[AW-1:0];
        wr_data   = res_q;
        cnt_d     = cnt_m1;
        done_d    = 1'b1;
        status_d  = ST_OK;
        value_d   = res_q;
        depth_ext = 32'(cnt_m1);
      end
      default: ;
    endcase
    depth_d = depth_ext[DEPTH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    it_q     <= it_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    value_q  <= value_d;
    depth_q  <= depth_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign value_o  = value_q;
  assign depth_o  = depth_q;

  // every result returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // the entry count never passes the stack size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond stack size");

  // a push with room answers ok in the next cycle and grows the stack
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(op_i) == OP_PUSH && !full) |=>
      (done_o && status_o == ST_OK && cnt_q == $past(cnt_q) + CW'(1)))
    else $error("push with room not completed");

  // a multi-cycle item never shows its result in its first busy cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("result strobe at start of multi-cycle item");

endmodule
`default_nettype wire

/* test/stack_rpn_calculator_unit_tb.sv */
// testbench of the rpn stack calculator: directed and random items checked against a shadow stack
`timescale 1ns / 1ps
module stack_rpn_calculator_unit_tb;
  import srpn_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  // longest stretch without an accepted item or a result strobe:
  // divide latency plus the longest gap, taken many times over
  localparam int unsigned STALL_LIMIT = 2000;
  // no idling once this few items are left
  localparam int unsigned QUIET_TAIL = 150;

  typedef struct {
    op_e               op;
    logic [DATA_W-1:0] operand;
    bit                hold;     // wait for every result before offering it
  } calc_item_t;

  typedef struct {
    status_e            status;
    logic [DATA_W-1:0]  value;
    logic [DEPTH_W-1:0] depth;
  } calc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [OP_W-1:0] op_i = '0;
  logic signed [DATA_W-1:0] operand_i = '0;
  logic busy;
  logic done_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [DATA_W-1:0] value_o;
  logic [DEPTH_W-1:0] depth_o;

  calc_item_t   pending_items[$];
  calc_result_t result_q[$];

  // shadow copy of the stack, updated at each accepted item
  logic [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned       shadow_count = 0;

  int unsigned  gap_left = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  fail_count = 0;
  calc_result_t seen_want;

  stack_rpn_calculator_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .op_i     (op_i),
    .operand_i(operand_i),
    .done_o   (done_o),
    .status_o (status_o),
    .value_o  (value_o),
    .depth_o  (depth_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one item to the shadow stack and work out the result it causes
  task automatic compute_result(input op_e op, input logic [DATA_W-1:0] operand,
                                output calc_result_t res);
    logic [DATA_W-1:0] lhs, rhs, lhs_mag, rhs_mag, outcome;
    res.status = ST_OK;
    res.value  = '0;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_stack[shadow_count] = operand;
          shadow_count++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = shadow_stack[shadow_count-1];
          if (op == OP_POP) shadow_count--;
        end
      end
      default: begin
        if (shadow_count < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          rhs = shadow_stack[shadow_count-1];
          lhs = shadow_stack[shadow_count-2];
          if ((op == OP_DIV || op == OP_MOD) && rhs == '0) begin
            // divisor of zero leaves both operands in place
            res.status = ST_DIVZERO;
          end else begin
            // sign and magnitude form for truncating division
            lhs_mag = lhs[DATA_W-1] ? ('0 - lhs) : lhs;
            rhs_mag = rhs[DATA_W-1] ? ('0 - rhs) : rhs;
            case (op)
              OP_ADD: outcome = lhs + rhs;
              OP_SUB: outcome = lhs - rhs;
              OP_MUL: outcome = lhs * rhs;
              OP_DIV: begin
                outcome = lhs_mag / rhs_mag;
                if (lhs[DATA_W-1] ^ rhs[DATA_W-1]) outcome = '0 - outcome;
              end
              default: begin
                // remainder follows the sign of the dividend
                outcome = lhs_mag % rhs_mag;
                if (lhs[DATA_W-1]) outcome = '0 - outcome;
              end
            endcase
            shadow_count--;
            shadow_stack[shadow_count-1] = outcome;
            res.value = outcome;
          end
        end
      end
    endcase
    res.depth = DEPTH_W'(shadow_count);
  endtask

  task automatic add_item(input op_e op, input logic [DATA_W-1:0] operand, input bit hold);
    calc_item_t it;
    it.op      = op;
    it.operand = operand;
    it.hold    = hold;
    pending_items.push_back(it);
  endtask

  // operand mix: extremes, zero and small values show up often
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      4:       return 32'd1;
      5, 6:    return DATA_W'($signed($urandom_range(0, 32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // weights in percent for push and for pop/peek, the rest are binary ops
  function automatic op_e pick_op(input int unsigned push_pct, input int unsigned read_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return OP_PUSH;
    if (roll < push_pct + read_pct) return $urandom_range(0, 1) ? OP_POP : OP_PEEK;
    return op_e'($urandom_range(OP_ADD, OP_MOD));
  endfunction

  // driver: offers the oldest pending item and predicts it once accepted
  always @(posedge clk_i) begin
    calc_result_t res;
    if (rst_ni) begin
      if (start && !busy) begin
        compute_result(pending_items[0].op, pending_items[0].operand, res);
        result_q.push_back(res);
        void'(pending_items.pop_front());
      end
      // random idle bursts, none in the tail of the run
      if (gap_left == 0 && pending_items.size() > QUIET_TAIL && $urandom_range(0, 15) == 0)
        gap_left = $urandom_range(1, 9);
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].hold && (result_q.size() != 0 || done_o))) begin
        // a held item waits until the last strobe has been taken
        start     <= 1'b1;
        op_i      <= pending_items[0].op;
        operand_i <= pending_items[0].operand;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $error("result strobe with no item outstanding");
        fail_count++;
      end else begin
        seen_want = result_q.pop_front();
        if (status_o !== seen_want.status) begin
          $error("status: expected %0d, actual %0d", seen_want.status, status_o);
          fail_count++;
        end
        if (value_o !== seen_want.value) begin
          $error("value: expected %0d, actual %0d", $signed(seen_want.value), value_o);
          fail_count++;
        end
        if (depth_o !== seen_want.depth) begin
          $error("depth: expected %0d, actual %0d", seen_want.depth, depth_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with neither an accepted item nor a strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned fill_pushes;
    int unsigned i;

    // directed: empty and underflow cases, extremes, divide by zero, wrap cases
    add_item(OP_POP,  32'd0, 1'b0);          // pop when empty
    add_item(OP_PEEK, 32'd0, 1'b0);          // peek when empty
    add_item(OP_ADD,  32'd0, 1'b0);          // binary op with no entries
    add_item(OP_PUSH, 32'h7fff_ffff, 1'b0);
    add_item(OP_MUL,  32'd0, 1'b0);          // binary op with one entry
    add_item(OP_PEEK, 32'hffff_ffff, 1'b0);
    add_item(OP_PUSH, 32'h8000_0000, 1'b0);
    add_item(OP_ADD,  32'd0, 1'b0);          // max + min = -1
    add_item(OP_PUSH, 32'h8000_0000, 1'b0);
    add_item(OP_SUB,  32'd0, 1'b0);          // -1 - min = max
    add_item(OP_PUSH, 32'd0, 1'b0);
    add_item(OP_DIV,  32'd0, 1'b0);          // divide by zero keeps operands
    add_item(OP_MOD,  32'd0, 1'b0);          // modulo by zero keeps operands
    add_item(OP_POP,  32'd0, 1'b0);
    add_item(OP_PUSH, 32'hffff_ffff, 1'b0);
    add_item(OP_MUL,  32'd0, 1'b0);          // max * -1
    add_item(OP_PUSH, 32'h8000_0000, 1'b0);
    add_item(OP_PUSH, 32'hffff_ffff, 1'b0);
    add_item(OP_DIV,  32'd0, 1'b0);          // min / -1 wraps to min
    add_item(OP_PUSH, 32'hffff_ffff, 1'b0);
    add_item(OP_MOD,  32'd0, 1'b0);          // min % -1 is zero
    add_item(OP_PUSH, 32'hffff_fff9, 1'b0);
    add_item(OP_PUSH, 32'd2, 1'b0);
    add_item(OP_MOD,  32'd0, 1'b0);          // -7 % 2 = -1, sign of dividend
    add_item(OP_PUSH, 32'd2, 1'b0);
    add_item(OP_DIV,  32'd0, 1'b0);          // -1 / 2 truncates to 0

    // mixed random traffic around small depths, with noise
    for (i = 0; i < 200; i++)
      add_item(pick_op(40, 20), pick_operand(), (i == 0) || ($urandom_range(0, 99) == 0));

    // fill past the top so pushes overflow, peeks scattered in
    fill_pushes = 0;
    add_item(OP_PEEK, $urandom, 1'b1);
    while (fill_pushes < DEPTH + 8) begin
      if ($urandom_range(0, 11) == 0) begin
        add_item(OP_PEEK, $urandom, 1'b0);
      end else begin
        add_item(OP_PUSH, pick_operand(), $urandom_range(0, 99) == 0);
        fill_pushes++;
      end
    end

    // unwind from a full stack with arithmetic and pops
    for (i = 0; i < 150; i++)
      add_item(pick_op(10, 30), pick_operand(), i == 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
